>>> src/rcr_pkg.sv
// shared types and constants for the rotating channel router
// frame request and result structs, register indexes, widths
// no dependencies
package rcr_pkg;

	localparam int SAMPLE_WIDTH   = 16;
	localparam int CONTROL_DIVIDE = 5;
	localparam int NUM_CH         = 8;
	localparam int CH_W           = 3;
	localparam int TICK_W         = $clog2(CONTROL_DIVIDE + 1);
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROUTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INACTIVE_PASS = 1'd1;

	localparam logic [CH_W-1:0] LAST_RESET = 3'd7;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample0;
		logic signed [SAMPLE_WIDTH-1:0] sample1;
		logic signed [SAMPLE_WIDTH-1:0] sample2;
		logic signed [SAMPLE_WIDTH-1:0] sample3;
		logic signed [SAMPLE_WIDTH-1:0] sample4;
		logic signed [SAMPLE_WIDTH-1:0] sample5;
		logic signed [SAMPLE_WIDTH-1:0] sample6;
		logic signed [SAMPLE_WIDTH-1:0] sample7;
		logic                           gate_up;
		logic                           gate_down;
		logic                           gate_reset;
		logic [NUM_CH-1:0]              connected_mask;
	} rcr_req_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] out0;
		logic signed [SAMPLE_WIDTH-1:0] out1;
		logic signed [SAMPLE_WIDTH-1:0] out2;
		logic signed [SAMPLE_WIDTH-1:0] out3;
		logic signed [SAMPLE_WIDTH-1:0] out4;
		logic signed [SAMPLE_WIDTH-1:0] out5;
		logic signed [SAMPLE_WIDTH-1:0] out6;
		logic signed [SAMPLE_WIDTH-1:0] out7;
		logic [CH_W-1:0]                rotation;
		logic [CH_W-1:0]                last_active;
	} rcr_rsp_t;

endpackage

>>> src/rotating_channel_router.sv
// eight-channel rotating crossbar: input register, routing and offset update, result register
// depends on rcr_pkg
// a request passes through the input register, then the result register
// throughput: one request per cycle unless out_stall holds a valid result; the offset and
// last-index update is one pass of logic between the input register and the result register
// reset: offset 0, last index 7, tick counter 0, gate history low, config registers 0
module rotating_channel_router
	import rcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rcr_req_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rcr_rsp_t              out_data
);

	logic [CH_W-1:0]   active_routes_q;
	logic              inactive_pass_q;
	logic [CH_W-1:0]   offset_q;
	logic [CH_W-1:0]   last_q;
	logic [TICK_W-1:0] tick_q;
	logic [2:0]        prev_gates_q;

	logic     valid_s1;
	rcr_req_t req_s1;
	logic     out_valid_q;
	rcr_rsp_t out_data_q;

	logic adv;
	logic tick;
	logic [CH_W-1:0] auto_last;
	logic [CH_W-1:0] last_tick;
	logic [CH_W-1:0] last_new;
	logic [2:0]      gates;
	logic [2:0]      rise;
	logic [CH_W-1:0] off1;
	logic [CH_W-1:0] off2;
	logic [CH_W-1:0] off3;
	logic [CH_W-1:0] off_tick;
	logic [CH_W-1:0] offset_new;
	logic [2:0]      prev_new;
	logic [TICK_W-1:0] tick_new;
	logic [SAMPLE_WIDTH-1:0] smp [NUM_CH];
	logic [SAMPLE_WIDTH-1:0] routed [NUM_CH];
	rcr_rsp_t rsp;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_routes_q <= '0;
			inactive_pass_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_ROUTES: active_routes_q <= cfg_data[CH_W-1:0];
				REG_INACTIVE_PASS: inactive_pass_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	// control tick and offset update
	always_comb begin
		auto_last = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			if (req_s1.connected_mask[k]) begin
				auto_last = CH_W'(k);
			end
		end
		tick      = (tick_q == TICK_W'(CONTROL_DIVIDE - 1));
		tick_new  = tick ? '0 : tick_q + TICK_W'(1);
		last_tick = (active_routes_q != '0) ? active_routes_q : auto_last;
		last_new  = tick ? last_tick : last_q;

		gates = {req_s1.gate_reset, req_s1.gate_down, req_s1.gate_up};
		rise  = gates & ~prev_gates_q;
		prev_new = tick ? gates : prev_gates_q;

		off1 = offset_q;
		if (rise[0]) begin
			off1 = (offset_q == '0) ? last_tick : offset_q - CH_W'(1);
		end
		off2 = off1;
		if (rise[1]) begin
			off2 = (off1 >= last_tick) ? '0 : off1 + CH_W'(1);
		end
		off3 = rise[2] ? '0 : off2;
		off_tick   = tick ? off3 : offset_q;
		offset_new = (off_tick > last_new) ? last_new : off_tick;
	end

	// routing
	always_comb begin
		smp[0] = req_s1.sample0;
		smp[1] = req_s1.sample1;
		smp[2] = req_s1.sample2;
		smp[3] = req_s1.sample3;
		smp[4] = req_s1.sample4;
		smp[5] = req_s1.sample5;
		smp[6] = req_s1.sample6;
		smp[7] = req_s1.sample7;
		for (int j = 0; j < NUM_CH; j++) begin
			if (CH_W'(j) > last_new) begin
				routed[j] = inactive_pass_q ? smp[j] : '0;
			end else if (CH_W'(j) >= offset_new) begin
				routed[j] = smp[CH_W'(j) - offset_new];
			end else begin
				routed[j] = smp[CH_W'(j) + last_new + CH_W'(1) - offset_new];
			end
		end
		rsp.out0        = routed[0];
		rsp.out1        = routed[1];
		rsp.out2        = routed[2];
		rsp.out3        = routed[3];
		rsp.out4        = routed[4];
		rsp.out5        = routed[5];
		rsp.out6        = routed[6];
		rsp.out7        = routed[7];
		rsp.rotation    = offset_new;
		rsp.last_active = last_new;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= '0;
			last_q       <= LAST_RESET;
			tick_q       <= '0;
			prev_gates_q <= '0;
		end else if (adv) begin
			offset_q     <= offset_new;
			last_q       <= last_new;
			tick_q       <= tick_new;
			prev_gates_q <= prev_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= rsp;
		end
	end

	a_offset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= last_q)
		else $error("offset beyond last active index");

	a_rotation_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.rotation <= out_data_q.last_active)
		else $error("result rotation beyond last active index");

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < TICK_W'(CONTROL_DIVIDE))
		else $error("tick counter out of range");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("input stage lost a request");

endmodule

>>> sim/tb_rotating_channel_router.sv
`timescale 1ns / 100ps
// self-checking testbench for rotating_channel_router: directed table, then random frames
// over several routing settings and idle patterns; results checked against an inline predictor
// depends on rcr_pkg and rotating_channel_router
module tb_rotating_channel_router;
	import rcr_pkg::*;

	localparam int REQ_W       = $bits(rcr_req_t);
	localparam int RSP_W       = $bits(rcr_rsp_t);
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 190;

	typedef enum logic [1:0] {PREDICTED, SAME_ORDER, CH0_ONLY} want_kind_t;

	typedef struct packed {
		logic [2:0]   gates;
		logic [7:0]   mask;
		want_kind_t   how;
	} dir_row_t;

	// gates are {reset, down, up}; every fifth request is a control tick
	localparam dir_row_t DIR_ROWS [25] = '{
		'{3'b000, 8'h00, SAME_ORDER},
		'{3'b001, 8'hFF, SAME_ORDER},
		'{3'b110, 8'h5A, SAME_ORDER},
		'{3'b000, 8'hA5, SAME_ORDER},
		'{3'b001, 8'hFF, PREDICTED},
		'{3'b000, 8'h00, PREDICTED},
		'{3'b111, 8'h0F, PREDICTED},
		'{3'b010, 8'h80, PREDICTED},
		'{3'b000, 8'h01, PREDICTED},
		'{3'b000, 8'hFF, PREDICTED},
		'{3'b001, 8'h00, PREDICTED},
		'{3'b100, 8'hFF, PREDICTED},
		'{3'b011, 8'h3C, PREDICTED},
		'{3'b000, 8'hC3, PREDICTED},
		'{3'b001, 8'h07, PREDICTED},
		'{3'b000, 8'hFF, PREDICTED},
		'{3'b110, 8'h00, PREDICTED},
		'{3'b101, 8'hAA, PREDICTED},
		'{3'b000, 8'h55, PREDICTED},
		'{3'b010, 8'h01, PREDICTED},
		'{3'b000, 8'hFE, PREDICTED},
		'{3'b101, 8'h00, PREDICTED},
		'{3'b011, 8'hFF, PREDICTED},
		'{3'b000, 8'h80, PREDICTED},
		'{3'b101, 8'h00, CH0_ONLY}
	};

	localparam int PLAN_ROUTES [6] = '{0, 7, 1, 3, 0, 5};
	localparam int PLAN_PASS   [6] = '{1, 0, 1, 0, 0, 1};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ACTIVE_ROUTES;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	rcr_req_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	rcr_rsp_t              out_data;

	rotating_channel_router dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// predictor state
	logic [CH_W-1:0] rot_offset;
	logic [CH_W-1:0] last_idx;
	int              tick_cnt;
	logic [2:0]      prev_gates;
	logic [CH_W-1:0] cfg_routes;
	logic            cfg_pass;

	rcr_rsp_t pending_routes [$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic logic [SAMPLE_WIDTH-1:0] corner_sample(input int n);
		case (n % 6)
			0: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			2: return '0;
			3: return '1;
			4: return {(SAMPLE_WIDTH/2){2'b01}};
			default: return {(SAMPLE_WIDTH/2){2'b10}};
		endcase
	endfunction

	function automatic rcr_rsp_t route_frame(input rcr_req_t f);
		rcr_rsp_t                r;
		logic [CH_W-1:0]         lim;
		logic [2:0]              gates;
		logic [2:0]              rise;
		int                      off;
		int                      dst;
		logic [SAMPLE_WIDTH-1:0] s;
		tick_cnt++;
		if (tick_cnt >= CONTROL_DIVIDE) begin
			tick_cnt = 0;
			lim = cfg_routes;
			if (lim == 0) begin
				for (int i = 0; i < NUM_CH; i++)
					if (f.connected_mask[i])
						lim = i[CH_W-1:0];
			end
			last_idx = lim;
			gates = {f.gate_reset, f.gate_down, f.gate_up};
			rise = gates & ~prev_gates;
			prev_gates = gates;
			off = int'(rot_offset);
			if (rise[0]) begin
				off--;
				if (off < 0)
					off = int'(last_idx);
			end
			if (rise[1]) begin
				off++;
				if (off > int'(last_idx))
					off = 0;
			end
			if (rise[2])
				off = 0;
			rot_offset = off[CH_W-1:0];
		end
		if (rot_offset > last_idx)
			rot_offset = last_idx;
		r = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			s = f[REQ_W-1-SAMPLE_WIDTH*i -: SAMPLE_WIDTH];
			if (i > int'(last_idx)) begin
				r[RSP_W-1-SAMPLE_WIDTH*i -: SAMPLE_WIDTH] = cfg_pass ? s : '0;
			end else begin
				dst = (int'(rot_offset) + i) % (int'(last_idx) + 1);
				r[RSP_W-1-SAMPLE_WIDTH*dst -: SAMPLE_WIDTH] = s;
			end
		end
		r.rotation = rot_offset;
		r.last_active = last_idx;
		return r;
	endfunction

	function automatic rcr_req_t random_frame();
		rcr_req_t f;
		f = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			if ($urandom_range(0, 7) == 0)
				f[REQ_W-1-SAMPLE_WIDTH*k -: SAMPLE_WIDTH] = corner_sample($urandom_range(0, 5));
			else
				f[REQ_W-1-SAMPLE_WIDTH*k -: SAMPLE_WIDTH] = SAMPLE_WIDTH'($urandom);
		end
		{f.gate_reset, f.gate_down, f.gate_up} = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 9) == 0)
			f.connected_mask = '0;
		else
			f.connected_mask = NUM_CH'($urandom & ((1 << ($urandom_range(0, 7) + 1)) - 1));
		return f;
	endfunction

	task automatic send_frame(input rcr_req_t f, input want_kind_t how);
		rcr_rsp_t guess;
		bit       taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		guess = route_frame(f);
		case (how)
			SAME_ORDER: guess = {f[REQ_W-1 -: NUM_CH*SAMPLE_WIDTH], 3'd0, LAST_RESET};
			CH0_ONLY:   guess = {f.sample0, {((NUM_CH-1)*SAMPLE_WIDTH){1'b0}}, 3'd0, 3'd0};
			default:    ;
		endcase
		pending_routes.push_back(guess);
	endtask

	// sender holds off until every result is back, then lets the pipe settle
	task automatic drain_results(input int settle);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_routes.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_routing(input logic [CH_W-1:0] routes, input logic [CFG_DATA_W-1:0] pass);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACTIVE_ROUTES;
		cfg_data <= routes;
		@(posedge clk);
		cfg_index <= REG_INACTIVE_PASS;
		cfg_data <= pass;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_routes = routes;
		cfg_pass = pass[0];
	endtask

	always @(negedge clk) begin
		rcr_rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_routes.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result %h", $time, out_data);
			end else begin
				want = pending_routes.pop_front();
				for (int k = 0; k < NUM_CH; k++) begin
					if (out_data[RSP_W-1-SAMPLE_WIDTH*k -: SAMPLE_WIDTH] !==
					    want[RSP_W-1-SAMPLE_WIDTH*k -: SAMPLE_WIDTH]) begin
						mismatch_count++;
						$display("%0t: out%0d expected %0d got %0d", $time, k,
							$signed(want[RSP_W-1-SAMPLE_WIDTH*k -: SAMPLE_WIDTH]),
							$signed(out_data[RSP_W-1-SAMPLE_WIDTH*k -: SAMPLE_WIDTH]));
					end
				end
				if (out_data.rotation !== want.rotation) begin
					mismatch_count++;
					$display("%0t: rotation expected %0d got %0d", $time,
						want.rotation, out_data.rotation);
				end
				if (out_data.last_active !== want.last_active) begin
					mismatch_count++;
					$display("%0t: last_active expected %0d got %0d", $time,
						want.last_active, out_data.last_active);
				end
			end
		end
	end

	initial begin
		rcr_req_t        f;
		logic [CH_W-1:0] routes;
		logic            pass;
		rot_offset = '0;
		last_idx = LAST_RESET;
		tick_cnt = 0;
		prev_gates = '0;
		cfg_routes = '0;
		cfg_pass = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 25; r++) begin
			for (int k = 0; k < NUM_CH; k++)
				f[REQ_W-1-SAMPLE_WIDTH*k -: SAMPLE_WIDTH] = corner_sample(r + k);
			{f.gate_reset, f.gate_down, f.gate_up} = DIR_ROWS[r].gates;
			f.connected_mask = DIR_ROWS[r].mask;
			send_frame(f, DIR_ROWS[r].how);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results(4);
			if (ph < 6) begin
				routes = CH_W'(PLAN_ROUTES[ph]);
				pass = 1'(PLAN_PASS[ph]);
			end else begin
				routes = CH_W'($urandom_range(0, 7));
				pass = 1'($urandom_range(0, 1));
			end
			set_routing(routes, {2'($urandom_range(0, 3)), pass});
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain_results(0);
				send_frame(random_frame(), PREDICTED);
			end
		end

		drain_results(8);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
